// File: design/missing_sequence_range_set_defines.svh
// Assertion macros for the missing-sequence range set.
`ifndef MISSING_SEQUENCE_RANGE_SET_DEFINES_SVH
`define MISSING_SEQUENCE_RANGE_SET_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSRS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("missing_sequence_range_set: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MSRS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("missing_sequence_range_set: next-cycle check failed");

`endif

// File: design/msrs_pkg.sv
// Shared types and codes for the missing-sequence range set.
package msrs_pkg;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
    } t_range;

    typedef struct packed {
        logic   wr_en;
        t_range wr;
        logic   extra_en;
        t_range extra;
        t_range acc;
        logic   placed;
        logic   hit;
    } t_eval;

endpackage

// File: design/missing_sequence_range_set.sv
// Top level of the missing-sequence range set: sequencer, table banks and result register.
//
//  channel | signals                                          | direction
//  in      | i_in_valid, o_in_ready, i_action, i_first_seq,   | into block
//          | i_last_seq                                       |
//  out     | o_out_valid, i_out_ready, o_is_missing,          | out of block
//          | o_overflow, o_ranges_held                        |
//
// An item streams the n stored intervals through the compare unit from one bank into the
// other, one per cycle but for an extra write step in S_EXTRA on a split or an insertion;
// an add also ends with a step in S_TAIL that writes the range if it met no later interval.
// A reversed add or an unused action code skips the scan.
// The single read port of the table memory paces the scan. The input is not ready while an
// item is in work, and a finished item waits for a free result register if the output stalls.
// Reset empties the table at once; no clearing pass is needed.
module missing_sequence_range_set #(
    parameter int MAX_RANGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_first_seq,
    input  logic [31:0] i_last_seq,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_is_missing,
    output logic        o_overflow,
    output logic [4:0]  o_ranges_held
);

    localparam int IW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int AW = IW + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RUN   = 5'b00010,
        S_EXTRA = 5'b00100,
        S_TAIL  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic             r_bank, n_bank;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_wptr, n_wptr;
    logic [1:0]       r_action, n_action;
    logic [31:0]      r_first, n_first;
    logic [31:0]      r_last, n_last;
    msrs_pkg::t_range r_acc, n_acc;
    msrs_pkg::t_range r_pend, n_pend;
    logic             r_placed, n_placed;
    logic             r_ovf, n_ovf;
    logic             r_miss, n_miss;
    logic             r_commit, n_commit;
    logic             r_out_valid, n_out_valid;
    logic             r_out_miss, n_out_miss;
    logic             r_out_ovf, n_out_ovf;
    logic [4:0]       r_out_held, n_out_held;

    logic             wreq;
    msrs_pkg::t_range wdata;
    logic             mem_we;
    logic             mem_re;
    logic [IW-1:0]    rd_idx;
    msrs_pkg::t_range mem_rdata;
    msrs_pkg::t_eval  ev;
    logic [CW-1:0]    next_idx;
    logic             accept;
    logic             table_full_wr;

    msrs_mem #(
        .AW(AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr ({~r_bank, r_wptr[IW-1:0]}),
        .i_wdata (wdata),
        .i_re    (mem_re),
        .i_raddr ({r_bank, rd_idx}),
        .o_rdata (mem_rdata)
    );

    msrs_eval u_eval (
        .i_action (r_action),
        .i_first  (r_first),
        .i_last   (r_last),
        .i_entry  (mem_rdata),
        .i_acc    (r_acc),
        .i_placed (r_placed),
        .o_res    (ev)
    );

    assign accept        = i_in_valid && o_in_ready;
    assign next_idx      = r_idx + CW'(1);
    assign table_full_wr = r_wptr == CW'(MAX_RANGES);

    always_comb begin
        n_state     = r_state;
        n_bank      = r_bank;
        n_count     = r_count;
        n_idx       = r_idx;
        n_wptr      = r_wptr;
        n_action    = r_action;
        n_first     = r_first;
        n_last      = r_last;
        n_acc       = r_acc;
        n_pend      = r_pend;
        n_placed    = r_placed;
        n_ovf       = r_ovf;
        n_miss      = r_miss;
        n_commit    = r_commit;
        n_out_valid = r_out_valid;
        n_out_miss  = r_out_miss;
        n_out_ovf   = r_out_ovf;
        n_out_held  = r_out_held;
        wreq        = 1'b0;
        wdata       = r_acc;
        mem_re      = 1'b0;
        rd_idx      = '0;
        mem_we      = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_action = i_action;
                    n_first  = i_first_seq;
                    n_last   = i_last_seq;
                    n_acc    = '{lo: i_first_seq, hi: i_last_seq};
                    n_placed = 1'b0;
                    n_ovf    = 1'b0;
                    n_miss   = 1'b0;
                    n_wptr   = '0;
                    n_idx    = '0;
                    n_commit = ((i_action == msrs_pkg::ACT_ADD) && (i_first_seq <= i_last_seq))
                               || (i_action == msrs_pkg::ACT_REMOVE);
                    if ((i_action == msrs_pkg::ACT_ADD) && (i_first_seq > i_last_seq)) begin
                        n_state = S_DONE;
                    end else if ((i_action != msrs_pkg::ACT_ADD)
                                 && (i_action != msrs_pkg::ACT_REMOVE)
                                 && (i_action != msrs_pkg::ACT_QUERY)) begin
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        n_state = (i_action == msrs_pkg::ACT_ADD) ? S_TAIL : S_DONE;
                    end else begin
                        mem_re  = 1'b1;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                n_acc    = ev.acc;
                n_placed = ev.placed;
                if (ev.hit) begin
                    n_miss = 1'b1;
                end
                wreq  = ev.wr_en;
                wdata = ev.wr;
                if (ev.extra_en) begin
                    n_pend  = ev.extra;
                    n_state = S_EXTRA;
                end else if (next_idx < r_count) begin
                    mem_re  = 1'b1;
                    rd_idx  = next_idx[IW-1:0];
                    n_idx   = next_idx;
                end else begin
                    n_state = (r_action == msrs_pkg::ACT_ADD) ? S_TAIL : S_DONE;
                end
            end
            S_EXTRA: begin
                wreq  = 1'b1;
                wdata = r_pend;
                if (next_idx < r_count) begin
                    mem_re  = 1'b1;
                    rd_idx  = next_idx[IW-1:0];
                    n_idx   = next_idx;
                    n_state = S_RUN;
                end else begin
                    n_state = (r_action == msrs_pkg::ACT_ADD) ? S_TAIL : S_DONE;
                end
            end
            S_TAIL: begin
                // A range that met no later interval goes last.
                wreq    = !r_placed;
                wdata   = r_acc;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_miss  = r_miss;
                    n_out_ovf   = r_ovf;
                    n_state     = S_IDLE;
                    if (r_commit && !r_ovf) begin
                        n_bank     = ~r_bank;
                        n_count    = r_wptr;
                        n_out_held = 5'(r_wptr);
                    end else begin
                        n_out_held = 5'(r_count);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A write past capacity means the new table would not fit: keep the old bank.
        if (wreq) begin
            if (table_full_wr) begin
                n_ovf = 1'b1;
            end else begin
                mem_we = 1'b1;
                n_wptr = r_wptr + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bank      <= n_bank;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_wptr     <= n_wptr;
        r_action   <= n_action;
        r_first    <= n_first;
        r_last     <= n_last;
        r_acc      <= n_acc;
        r_pend     <= n_pend;
        r_placed   <= n_placed;
        r_ovf      <= n_ovf;
        r_miss     <= n_miss;
        r_commit   <= n_commit;
        r_out_miss <= n_out_miss;
        r_out_ovf  <= n_out_ovf;
        r_out_held <= n_out_held;
    end

    assign o_in_ready    = r_state == S_IDLE;
    assign o_out_valid   = r_out_valid;
    assign o_is_missing  = r_out_miss;
    assign o_overflow    = r_out_ovf;
    assign o_ranges_held = r_out_held;

`include "missing_sequence_range_set_defines.svh"

    `MSRS_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(r_state))
    `MSRS_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CW'(MAX_RANGES))
    `MSRS_ASSERT_NOW(a_write_busy, mem_we, (r_state != S_IDLE) && (r_state != S_DONE))
    `MSRS_ASSERT_NOW(a_ovf_full, o_out_valid && o_overflow, o_ranges_held == 5'(MAX_RANGES))
    `MSRS_ASSERT_NEXT(a_busy_after_take, i_in_valid && o_in_ready, !o_in_ready)

endmodule

// File: design/msrs_mem.sv
// Interval table storage: two banks in one array, one write and one registered read port.
module msrs_mem #(
    parameter int AW = 5
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  msrs_pkg::t_range       i_wdata,
    input  logic                   i_re,
    input  logic [AW-1:0]          i_raddr,
    output msrs_pkg::t_range       o_rdata
);

    msrs_pkg::t_range r_mem [(1 << AW)];
    msrs_pkg::t_range r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/msrs_eval.sv
// Shared compare unit: decides what one stored interval turns into for the current operation.
module msrs_eval (
    input  logic [1:0]         i_action,
    input  logic [31:0]        i_first,
    input  logic [31:0]        i_last,
    input  msrs_pkg::t_range   i_entry,
    input  msrs_pkg::t_range   i_acc,
    input  logic               i_placed,
    output msrs_pkg::t_eval    o_res
);

    logic        ahead;
    logic        touch;
    logic        hit;
    logic [32:0] hi_p1;
    logic [32:0] last_p1;

    assign hi_p1   = {1'b0, i_entry.hi} + 33'd1;
    assign last_p1 = {1'b0, i_last} + 33'd1;
    // The interval ends more than one below the new range, so it stays ahead of it.
    assign ahead   = hi_p1 < {1'b0, i_first};
    assign touch   = {1'b0, i_entry.lo} <= last_p1;
    assign hit     = (i_entry.lo <= i_first) && (i_first <= i_entry.hi);

    always_comb begin
        o_res          = '0;
        o_res.wr       = i_entry;
        o_res.extra    = i_entry;
        o_res.acc      = i_acc;
        o_res.placed   = i_placed;
        case (i_action)
            msrs_pkg::ACT_ADD: begin
                if (i_placed || ahead) begin
                    o_res.wr_en = 1'b1;
                end else if (touch) begin
                    if (i_entry.lo < i_acc.lo) begin
                        o_res.acc.lo = i_entry.lo;
                    end
                    if (i_entry.hi > i_acc.hi) begin
                        o_res.acc.hi = i_entry.hi;
                    end
                end else begin
                    // First interval beyond the range: the merged range goes out ahead of it.
                    o_res.wr_en    = 1'b1;
                    o_res.wr       = i_acc;
                    o_res.extra_en = 1'b1;
                    o_res.placed   = 1'b1;
                end
            end
            msrs_pkg::ACT_REMOVE: begin
                if (hit) begin
                    if (i_entry.lo == i_first && i_entry.hi == i_first) begin
                        o_res.wr_en = 1'b0;
                    end else if (i_entry.lo == i_first) begin
                        o_res.wr_en = 1'b1;
                        o_res.wr.lo = i_first + 32'd1;
                    end else if (i_entry.hi == i_first) begin
                        o_res.wr_en = 1'b1;
                        o_res.wr.hi = i_first - 32'd1;
                    end else begin
                        o_res.wr_en    = 1'b1;
                        o_res.wr.hi    = i_first - 32'd1;
                        o_res.extra_en = 1'b1;
                        o_res.extra.lo = i_first + 32'd1;
                    end
                end else begin
                    o_res.wr_en = 1'b1;
                end
            end
            msrs_pkg::ACT_QUERY: begin
                o_res.hit = hit;
            end
            default: begin
                o_res.wr_en = 1'b0;
            end
        endcase
    end

endmodule

// File: tb/sv/tb.sv
// Testbench for the missing-sequence range set: directed and random beats against a table model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;

    typedef struct packed {
        logic       is_missing;
        logic       overflow;
        logic [4:0] ranges_held;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_action = msrs_pkg::ACT_QUERY;
    logic [31:0] i_first_seq = '0;
    logic [31:0] i_last_seq = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_is_missing;
    logic        o_overflow;
    logic [4:0]  o_ranges_held;

    // Local copy of the interval table, kept sorted like the block's.
    logic [31:0] gap_lo [TABLE_DEPTH];
    logic [31:0] gap_hi [TABLE_DEPTH];
    int          gap_count = 0;

    t_result     pending_results[$];
    t_result     oldest;
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    missing_sequence_range_set #(
        .MAX_RANGES(TABLE_DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_first_seq  (i_first_seq),
        .i_last_seq   (i_last_seq),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_is_missing (o_is_missing),
        .o_overflow   (o_overflow),
        .o_ranges_held(o_ranges_held)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one beat to the local table and returns the result it should produce.
    function automatic t_result apply_gap_op(logic [1:0] act, logic [31:0] a, logic [31:0] b);
        t_result     r;
        int          idx;
        int          first_hit;
        int          found;
        int          k;
        logic [31:0] lo;
        logic [31:0] hi;
        r = '0;
        case (act)
            msrs_pkg::ACT_ADD: begin
                if (a <= b) begin
                    idx = 0;
                    // Bounds are widened to 33 bits so that touching at the top of the
                    // sequence space does not wrap.
                    while (idx < gap_count && {1'b0, gap_hi[idx]} + 33'd1 < {1'b0, a})
                        idx++;
                    first_hit = idx;
                    lo = a;
                    hi = b;
                    while (idx < gap_count && {1'b0, gap_lo[idx]} <= {1'b0, b} + 33'd1) begin
                        if (gap_lo[idx] < lo) lo = gap_lo[idx];
                        if (gap_hi[idx] > hi) hi = gap_hi[idx];
                        idx++;
                    end
                    if (idx == first_hit) begin
                        if (gap_count >= TABLE_DEPTH) begin
                            r.overflow = 1'b1;
                        end else begin
                            for (k = gap_count; k > first_hit; k--) begin
                                gap_lo[k] = gap_lo[k - 1];
                                gap_hi[k] = gap_hi[k - 1];
                            end
                            gap_lo[first_hit] = lo;
                            gap_hi[first_hit] = hi;
                            gap_count++;
                        end
                    end else begin
                        gap_lo[first_hit] = lo;
                        gap_hi[first_hit] = hi;
                        for (k = idx; k < gap_count; k++) begin
                            gap_lo[first_hit + 1 + (k - idx)] = gap_lo[k];
                            gap_hi[first_hit + 1 + (k - idx)] = gap_hi[k];
                        end
                        gap_count = gap_count - (idx - first_hit) + 1;
                    end
                end
            end
            msrs_pkg::ACT_REMOVE: begin
                found = -1;
                for (idx = 0; idx < gap_count; idx++) begin
                    if (gap_lo[idx] > a) break;
                    if (a <= gap_hi[idx]) begin
                        found = idx;
                        break;
                    end
                end
                if (found >= 0) begin
                    if (gap_lo[found] == a && gap_hi[found] == a) begin
                        for (k = found; k + 1 < gap_count; k++) begin
                            gap_lo[k] = gap_lo[k + 1];
                            gap_hi[k] = gap_hi[k + 1];
                        end
                        gap_count--;
                    end else if (gap_lo[found] == a) begin
                        gap_lo[found] = a + 32'd1;
                    end else if (gap_hi[found] == a) begin
                        gap_hi[found] = a - 32'd1;
                    end else if (gap_count >= TABLE_DEPTH) begin
                        r.overflow = 1'b1;
                    end else begin
                        for (k = gap_count; k > found; k--) begin
                            gap_lo[k] = gap_lo[k - 1];
                            gap_hi[k] = gap_hi[k - 1];
                        end
                        gap_hi[found] = a - 32'd1;
                        gap_lo[found + 1] = a + 32'd1;
                        gap_count++;
                    end
                end
            end
            msrs_pkg::ACT_QUERY: begin
                for (idx = 0; idx < gap_count; idx++)
                    if (gap_lo[idx] <= a && a <= gap_hi[idx]) r.is_missing = 1'b1;
            end
            default: ;
        endcase
        r.ranges_held = gap_count[4:0];
        return r;
    endfunction

    // Sends one beat, with a random gap ahead of it, and records what it should produce.
    task automatic send_item(input logic [1:0] act, input logic [31:0] a, input logic [31:0] b);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_first_seq <= a;
        i_last_seq  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.insert(pending_results.size(), apply_gap_op(act, a, b));
    endtask

    // A number from a stored interval, so that removes and queries often hit.
    function automatic logic [31:0] pick_stored_number();
        int idx;
        idx = $urandom_range(0, gap_count - 1);
        case ($urandom_range(0, 3))
            0:       return gap_lo[idx];
            1:       return gap_hi[idx];
            default: return gap_lo[idx] + $urandom_range(0, gap_hi[idx] - gap_lo[idx]);
        endcase
    endfunction

    task automatic test_extremes();
        send_item(msrs_pkg::ACT_QUERY, 32'h0, 32'h0);
        send_item(msrs_pkg::ACT_REMOVE, 32'h5, 32'h0);
        send_item(msrs_pkg::ACT_ADD, 32'h0, 32'h0);
        send_item(msrs_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(msrs_pkg::ACT_ADD, 32'h40, 32'h3F);
        send_item(msrs_pkg::ACT_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(msrs_pkg::ACT_QUERY, 32'h1, 32'hFFFF_FFFF);
        send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(msrs_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_item(msrs_pkg::ACT_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    endtask

    task automatic test_merge_and_trim();
        send_item(msrs_pkg::ACT_ADD, 32'h2, 32'h3);
        // Fills the single gap between two intervals, so both fold into one.
        send_item(msrs_pkg::ACT_ADD, 32'h1, 32'h1);
        send_item(msrs_pkg::ACT_REMOVE, 32'h0, 32'h0);
        send_item(msrs_pkg::ACT_REMOVE, 32'h3, 32'h0);
        send_item(msrs_pkg::ACT_ADD, 32'h10, 32'h20);
        send_item(msrs_pkg::ACT_REMOVE, 32'h18, 32'h0);
        send_item(msrs_pkg::ACT_ADD, 32'h4, 32'h30);
    endtask

    task automatic test_full_table();
        logic [31:0] base;
        int          k;
        base = 32'h8000_0000;
        k = 0;
        while (gap_count < TABLE_DEPTH) begin
            send_item(msrs_pkg::ACT_ADD, base + 3 * k, base + 3 * k);
            k++;
        end
        send_item(msrs_pkg::ACT_ADD, base + 32'h1000, base + 32'h1001);
        // Merging with one neighbour needs no new entry, so a full table accepts it.
        send_item(msrs_pkg::ACT_ADD, base - 32'd1, base + 32'd1);
        send_item(msrs_pkg::ACT_REMOVE, base, 32'h0);
        send_item(msrs_pkg::ACT_QUERY, base, 32'h0);
        send_item(msrs_pkg::ACT_REMOVE, base + 32'd3, 32'h0);
        send_item(msrs_pkg::ACT_REMOVE, base, 32'h0);
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        logic [31:0] base;
        logic [31:0] a;
        logic [31:0] b;
        logic [32:0] span_end;
        int          sel;
        int          n;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        base = '0;
        for (n = 0; n < count; n++) begin
            // Work in a narrow window so that intervals crowd, merge and fill the table.
            if (n % 60 == 0) begin
                case ($urandom_range(0, 5))
                    0:       base = 32'h0;
                    1:       base = 32'hFFFF_FF00;
                    default: base = $urandom & 32'hFFFF_FF00;
                endcase
            end
            sel = $urandom_range(0, 99);
            a = base + $urandom_range(0, 255);
            if (sel < 45) begin
                span_end = {1'b0, a} + ((sel < 40) ? $urandom_range(0, 3) : $urandom_range(0, 64));
                b = span_end[32] ? 32'hFFFF_FFFF : span_end[31:0];
                send_item(msrs_pkg::ACT_ADD, a, b);
            end else if (sel < 70) begin
                if (gap_count > 0 && $urandom_range(0, 1)) a = pick_stored_number();
                send_item(msrs_pkg::ACT_REMOVE, a, $urandom);
            end else if (sel < 94) begin
                if (gap_count > 0 && $urandom_range(0, 1)) a = pick_stored_number();
                send_item(msrs_pkg::ACT_QUERY, a, $urandom);
            end else begin
                send_item(2'($urandom_range(0, 3)), $urandom, $urandom);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: missing %0b ovf %0b held %0d",
                         $time, o_is_missing, o_overflow, o_ranges_held);
                fail_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (o_is_missing !== oldest.is_missing) begin
                    $display("%0t: is_missing expected %0b actual %0b",
                             $time, oldest.is_missing, o_is_missing);
                    fail_count++;
                end
                if (o_overflow !== oldest.overflow) begin
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, oldest.overflow, o_overflow);
                    fail_count++;
                end
                if (o_ranges_held !== oldest.ranges_held) begin
                    $display("%0t: ranges_held expected %0d actual %0d",
                             $time, oldest.ranges_held, o_ranges_held);
                    fail_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        send_idle_pct = 13;
        recv_idle_pct = 45;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_merge_and_trim();
        test_full_table();
        test_random(283, 13, 45);
        test_random(283, 45, 13);
        test_random(284, 0, 0);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/msrs_pkg.sv
design/msrs_mem.sv
design/msrs_eval.sv
design/missing_sequence_range_set.sv
tb/sv/tb.sv
